// ===== hw/rtl/tun_pkg.sv =====
// Package for the triangle unit normal block: widths, pipeline depths and the
// bundle that rides alongside the square-root pipeline. No dependencies.
package tun_pkg;

   localparam int COORD_WIDTH      = 24;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int OUT_WIDTH        = 16;

   localparam int DIFF_W  = COORD_WIDTH + 1;     // edge vector component
   localparam int PROD_W  = 2 * DIFF_W;          // one product of the cross term
   localparam int CROSS_W = PROD_W + 1;          // signed cross term
   localparam int MAG_W   = PROD_W;              // cross term magnitude
   localparam int LO_W    = (MAG_W + 1) / 2;     // low half for partial products
   localparam int HI_W    = MAG_W - LO_W;
   localparam int SQ_W    = 2 * MAG_W;           // one square
   localparam int SUM_W   = SQ_W + 2;            // sum of three squares, even
   localparam int ROOT_W  = SUM_W / 2;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = NORMAL_FRAC_BITS + 1;
   localparam int REM_W   = ROOT_W + 2;
   localparam int QUO_W   = NORMAL_FRAC_BITS + 2;

   typedef struct packed {
      logic                        deg;
      logic [2:0]                  neg;
      logic [2:0][MAG_W-1:0]       mag;
   } tun_side_type;

endpackage

// ===== hw/rtl/tun_req_if.sv =====
// Request channel carrying the three triangle vertices.
// Depends on tun_pkg.
interface tun_req_if import tun_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] ax, ay, az;
   logic signed [COORD_WIDTH-1:0] bx, by_coord, bz;
   logic signed [COORD_WIDTH-1:0] cx, cy, cz;

   modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
   modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

// ===== hw/rtl/tun_rsp_if.sv =====
// Result channel carrying the unit normal and the degenerate flag.
// Depends on tun_pkg.
interface tun_rsp_if import tun_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] nx, ny, nz;
   logic                        degenerate;

   modport source (output valid, nx, ny, nz, degenerate, input ready);
   modport sink   (input valid, nx, ny, nz, degenerate, output ready);
endinterface

// ===== hw/rtl/tun_isqrt.sv =====
// Pipelined integer square root, two radicand bits per stage, with a sideband
// bundle that travels in step. Depends on tun_pkg.
module tun_isqrt import tun_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [SUM_W-1:0]   in_sum,
   input  tun_side_type       in_side,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root,
   output tun_side_type       out_side
);

   logic [SUM_W-1:0] num_ff  [ROOT_STEPS];
   logic [SUM_W-1:0] res_ff  [ROOT_STEPS];
   tun_side_type     side_ff [ROOT_STEPS];
   logic [ROOT_STEPS-1:0] valid_ff;

   genvar k;
   for (k = 0; k < ROOT_STEPS; k++) begin : g_step
      logic [SUM_W-1:0] num_src, res_src, trial, bitv, num_in, res_in;
      tun_side_type     side_src;
      logic             valid_src;

      if (k == 0) begin : g_first
         assign num_src   = in_sum;
         assign res_src   = '0;
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign num_src   = num_ff[k-1];
         assign res_src   = res_ff[k-1];
         assign side_src  = side_ff[k-1];
         assign valid_src = valid_ff[k-1];
      end

      assign bitv  = SUM_W'(1) << (SUM_W - 2 - 2 * k);
      assign trial = res_src + bitv;

      always_comb begin
         if (num_src >= trial) begin
            num_in = num_src - trial;
            res_in = (res_src >> 1) + bitv;
         end else begin
            num_in = num_src;
            res_in = res_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k]  <= num_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_STEPS-1];
   assign out_root  = ROOT_W'(res_ff[ROOT_STEPS-1]);
   assign out_side  = side_ff[ROOT_STEPS-1];

endmodule

// ===== hw/rtl/triangle_unit_normal.sv =====
// Triangle unit normal: one request per cycle, one result per request.
// Data passes through the edge, cross product and sum-of-squares stages, the square-root
// pipeline with a root bit from each stage, the dividers with a quotient bit from each
// stage, and one output register.
// Throughput is one request per cycle; the whole pipeline holds while a result waits.
// Synchronous active-high reset clears only the valid bits; other state is not reset.
module triangle_unit_normal import tun_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   tun_req_if.sink  req_chan,
   tun_rsp_if.source rsp_chan
);

   // The pipeline moves as a unit whenever the output register is free or
   // being emptied, so nothing is dropped or duplicated under backpressure.
   logic adv;
   logic out_valid_ff;
   assign adv = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Stage 1: edge vectors E = B - A and F = C - A.
   logic signed [DIFF_W-1:0] e_ff [3];
   logic signed [DIFF_W-1:0] f_ff [3];
   logic v1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff[0] <= DIFF_W'(req_chan.bx) - DIFF_W'(req_chan.ax);
         e_ff[1] <= DIFF_W'(req_chan.by_coord) - DIFF_W'(req_chan.ay);
         e_ff[2] <= DIFF_W'(req_chan.bz) - DIFF_W'(req_chan.az);
         f_ff[0] <= DIFF_W'(req_chan.cx) - DIFF_W'(req_chan.ax);
         f_ff[1] <= DIFF_W'(req_chan.cy) - DIFF_W'(req_chan.ay);
         f_ff[2] <= DIFF_W'(req_chan.cz) - DIFF_W'(req_chan.az);
      end
   end

   // Stage 2: the six products of the cross product, each one narrow multiplier.
   logic signed [PROD_W-1:0] pa_ff [3];
   logic signed [PROD_W-1:0] pb_ff [3];
   logic v2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff[0] <= e_ff[1] * f_ff[2];
         pb_ff[0] <= e_ff[2] * f_ff[1];
         pa_ff[1] <= e_ff[2] * f_ff[0];
         pb_ff[1] <= e_ff[0] * f_ff[2];
         pa_ff[2] <= e_ff[0] * f_ff[1];
         pb_ff[2] <= e_ff[1] * f_ff[0];
      end
   end

   // Stage 3: cross product terms, exact.
   logic signed [CROSS_W-1:0] n_ff [3];
   logic v3_ff;

   // Stage 4: sign and magnitude of each term.
   logic [2:0]       neg4_ff;
   logic [MAG_W-1:0] mag4_ff [3];
   logic v4_ff;

   // Stage 5: partial products of each square, split into halves.
   logic [2*HI_W-1:0]      hh_ff [3];
   logic [HI_W+LO_W-1:0]   hl_ff [3];
   logic [2*LO_W-1:0]      ll_ff [3];
   logic [2:0]             neg5_ff;
   logic [MAG_W-1:0]       mag5_ff [3];
   logic v5_ff;

   // Stage 6: the three squares.
   logic [SQ_W-1:0]  sq_ff [3];
   logic [2:0]       neg6_ff;
   logic [MAG_W-1:0] mag6_ff [3];
   logic v6_ff;

   // Stage 7: sum of squares and the degenerate test.
   logic [SUM_W-1:0] sum_ff;
   tun_side_type     side7_ff;
   logic v7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            n_ff[i]    <= CROSS_W'(pa_ff[i]) - CROSS_W'(pb_ff[i]);
            neg4_ff[i] <= n_ff[i][CROSS_W-1];
            mag4_ff[i] <= n_ff[i][CROSS_W-1] ? MAG_W'(-n_ff[i]) : MAG_W'(n_ff[i]);
            hh_ff[i]   <= mag4_ff[i][MAG_W-1:LO_W] * mag4_ff[i][MAG_W-1:LO_W];
            hl_ff[i]   <= mag4_ff[i][MAG_W-1:LO_W] * mag4_ff[i][LO_W-1:0];
            ll_ff[i]   <= mag4_ff[i][LO_W-1:0] * mag4_ff[i][LO_W-1:0];
            sq_ff[i]   <= (SQ_W'(hh_ff[i]) << (2 * LO_W))
                        + (SQ_W'(hl_ff[i]) << (LO_W + 1))
                        + SQ_W'(ll_ff[i]);
            mag5_ff[i] <= mag4_ff[i];
            mag6_ff[i] <= mag5_ff[i];
            side7_ff.mag[i] <= mag6_ff[i];
         end
         neg5_ff <= neg4_ff;
         neg6_ff <= neg5_ff;
         side7_ff.neg <= neg6_ff;
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         side7_ff.deg <= (sq_ff[0] == '0) && (sq_ff[1] == '0) && (sq_ff[2] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // Length of the cross product by a bit-per-stage square root.
   logic              rt_valid;
   logic [ROOT_W-1:0] rt_root;
   tun_side_type      rt_side;

   tun_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v7_ff),
      .in_sum    (sum_ff),
      .in_side   (side7_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   // Restoring division of each magnitude by the length: the first stage gives
   // the integer bit, the rest one fraction bit each.
   logic [REM_W-1:0]  rem_ff [DIV_STEPS][3];
   logic [QUO_W-1:0]  quo_ff [DIV_STEPS][3];
   logic [ROOT_W-1:0] len_ff [DIV_STEPS];
   logic [2:0]        dneg_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] ddeg_ff;
   logic [DIV_STEPS-1:0] dvalid_ff;

   genvar d, c;
   for (d = 0; d < DIV_STEPS; d++) begin : g_div
      logic [ROOT_W-1:0] len_src;
      logic [2:0]        neg_src;
      logic              deg_src, valid_src;

      if (d == 0) begin : g_first
         assign len_src   = rt_root;
         assign neg_src   = rt_side.neg;
         assign deg_src   = rt_side.deg;
         assign valid_src = rt_valid;
      end else begin : g_next
         assign len_src   = len_ff[d-1];
         assign neg_src   = dneg_ff[d-1];
         assign deg_src   = ddeg_ff[d-1];
         assign valid_src = dvalid_ff[d-1];
      end

      for (c = 0; c < 3; c++) begin : g_comp
         logic [REM_W-1:0] rem_sh, rem_in;
         logic [QUO_W-1:0] quo_src;
         logic             ge;

         if (d == 0) begin : g_first
            assign rem_sh  = REM_W'(rt_side.mag[c]);
            assign quo_src = '0;
         end else begin : g_next
            assign rem_sh  = rem_ff[d-1][c] << 1;
            assign quo_src = quo_ff[d-1][c];
         end

         assign ge     = rem_sh >= REM_W'(len_src);
         assign rem_in = ge ? rem_sh - REM_W'(len_src) : rem_sh;

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[d][c] <= rem_in;
               quo_ff[d][c] <= {quo_src[QUO_W-2:0], ge};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            len_ff[d]  <= len_src;
            dneg_ff[d] <= neg_src;
            ddeg_ff[d] <= deg_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dvalid_ff[d] <= 1'b0;
         end else if (adv) begin
            dvalid_ff[d] <= valid_src;
         end
      end
   end

   // Output register: sign, saturation to 16 bits, and zeroing for a
   // degenerate triangle, where the length is zero.
   logic [OUT_WIDTH-1:0] comp_in [3];
   logic [OUT_WIDTH-1:0] comp_ff [3];
   logic                 deg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [31:0] qx;
         qx = 32'(quo_ff[DIV_STEPS-1][i]);
         if (ddeg_ff[DIV_STEPS-1]) begin
            comp_in[i] = '0;
         end else if (dneg_ff[DIV_STEPS-1][i]) begin
            if (qx > 32'd32768) qx = 32'd32768;
            comp_in[i] = OUT_WIDTH'(32'd0 - qx);
         end else begin
            if (qx > 32'd32767) qx = 32'd32767;
            comp_in[i] = OUT_WIDTH'(qx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            comp_ff[i] <= comp_in[i];
         end
         deg_ff <= ddeg_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dvalid_ff[DIV_STEPS-1];
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.nx         = comp_ff[0];
   assign rsp_chan.ny         = comp_ff[1];
   assign rsp_chan.nz         = comp_ff[2];
   assign rsp_chan.degenerate = deg_ff;

endmodule
